FILE: hw/rtl/chc_pkg.sv
// Shared types, constants and the log2 fraction function of the hit clusterer.
`timescale 1ns / 1ps
package chc_pkg;

	localparam int FRAC_BITS = 12;
	localparam int LOG_W = 17;
	localparam int SUM_W = 40;
	localparam int SW_W = 23;
	localparam logic signed [17:0] LN2_Q12 = 18'sd2839;
	localparam logic REG_LOG_WEIGHT_REF = 1'b0;

	typedef struct packed {
		logic [5:0] row;
		logic [5:0] col;
		logic signed [24:0] energy;
		logic [15:0] stamp;
		logic signed [15:0] x;
		logic signed [15:0] y;
	} hit_t;

	typedef struct packed {
		logic done;
		logic [LOG_W-1:0] value;
	} log_res_t;

	typedef struct packed {
		logic done;
		logic signed [15:0] quotient;
	} div_res_t;

	// Fraction of log2(1 + k/2^bits) in Q12, by repeated squaring of a Q30 mantissa.
	function automatic logic [12:0] log_frac(input int unsigned k, input int unsigned bits);
		logic [63:0] m;
		logic [15:0] f;
		m = (64'd1 << 30) + (64'(k) << (30 - bits));
		f = '0;
		for (int b = 0; b < 16; b++) begin
			m = (m * m) >> 30;
			f = {f[14:0], 1'b0};
			if (m >= (64'd2 << 30)) begin
				m = m >> 1;
				f[0] = 1'b1;
			end
		end
		log_frac = 13'((17'(f) + 17'd8) >> 4);
	endfunction

endpackage

FILE: hw/rtl/chc_ram.sv
// Generic RAM with one write port and two registered read ports.
`timescale 1ns / 1ps
module chc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr_a,
	input  logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic [WIDTH-1:0]         rdata_a,
	output logic [WIDTH-1:0]         rdata_b
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_a <= mem_q[raddr_a];
		rdata_b <= mem_q[raddr_b];
	end
endmodule

FILE: hw/rtl/chc_log2.sv
// Iterative log2 unit: normalizes one bit per cycle, then reads the fraction table.
`timescale 1ns / 1ps
module chc_log2 #(
	parameter int LOG_TABLE_BITS = 6
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [31:0]       value,
	output chc_pkg::log_res_t res
);
	import chc_pkg::*;

	localparam int TAB_SIZE = 1 << LOG_TABLE_BITS;

	logic [12:0] frac_tab [TAB_SIZE];
	logic [31:0] v_q;
	logic [4:0] p_q;
	logic busy_q;
	logic done_q;
	logic [LOG_W-1:0] res_q;

	for (genvar g = 0; g < TAB_SIZE; g++) begin : g_tab
		assign frac_tab[g] = log_frac(g, LOG_TABLE_BITS);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
			p_q <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
			res_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				v_q <= value;
				p_q <= 5'd31;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				if (v_q[31]) begin
					res_q <= {p_q, 12'b0} + LOG_W'(frac_tab[v_q[30 -: LOG_TABLE_BITS]]);
					done_q <= 1'b1;
					busy_q <= 1'b0;
				end else begin
					v_q <= {v_q[30:0], 1'b0};
					p_q <= p_q - 5'd1;
				end
			end
		end
	end

	assign res.done = done_q;
	assign res.value = res_q;
endmodule

FILE: hw/rtl/chc_div.sv
// Restoring divider, one quotient bit per cycle, truncating toward zero.
`timescale 1ns / 1ps
module chc_div (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	input  logic signed [chc_pkg::SUM_W-1:0] dividend,
	input  logic [chc_pkg::SW_W-1:0]         divisor,
	output chc_pkg::div_res_t                res
);
	import chc_pkg::*;

	localparam logic [5:0] LAST_STEP = 6'(SUM_W - 1);

	logic [SUM_W-1:0] acc_q;
	logic [SW_W-1:0] rem_q;
	logic [5:0] cnt_q;
	logic busy_q;
	logic done_q;
	logic neg_q;
	logic [SW_W:0] rem_sh;
	logic [SW_W:0] rem_sub;
	logic ge;

	always_comb begin
		rem_sh = {rem_q, acc_q[SUM_W-1]};
		rem_sub = rem_sh - {1'b0, divisor};
		ge = rem_sh >= {1'b0, divisor};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
			rem_q <= '0;
			cnt_q <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
			neg_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				neg_q <= dividend[SUM_W-1];
				acc_q <= dividend[SUM_W-1] ? -dividend : dividend;
				rem_q <= '0;
				cnt_q <= '0;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				rem_q <= ge ? rem_sub[SW_W-1:0] : rem_sh[SW_W-1:0];
				acc_q <= {acc_q[SUM_W-2:0], ge};
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == LAST_STEP) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign res.done = done_q;
	assign res.quotient = neg_q ? -acc_q[15:0] : acc_q[15:0];
endmodule

FILE: hw/rtl/calorimeter_hit_clusterer.sv
// Top level of the calorimeter hit clusterer: hit store, union sequencer and cluster sums.
// Hits load at one per cycle while idle. After the last hit of an event, clustering
// initializes the labels, runs two passes of pairwise compares with a label sweep per
// cell merge, then per cluster sums the hits, weights each positive hit through the log2
// unit and forms the centroid in the shared divider; in_stall stays high until the last cluster transfers.
// Reset clears the event state and loads the reference weight with 4.2.
`timescale 1ns / 1ps
module calorimeter_hit_clusterer #(
	parameter int MAX_HITS = 64,
	parameter int GRID_DIM = 64,
	parameter int LOG_TABLE_BITS = 6
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [2:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [5:0]         hit_row,
	input  logic [5:0]         hit_col,
	input  logic signed [24:0] hit_energy,
	input  logic [15:0]        hit_time,
	input  logic signed [15:0] hit_x,
	input  logic signed [15:0] hit_y,
	input  logic               last_hit,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] cluster_energy,
	output logic [15:0]        time_begin,
	output logic [15:0]        time_end,
	output logic signed [15:0] x_center,
	output logic signed [15:0] y_center,
	output logic [6:0]         hit_count,
	output logic               centroid_valid,
	output logic               hits_dropped,
	output logic               last_cluster
);
	import chc_pkg::*;

	localparam int IDX_W = $clog2(MAX_HITS);
	localparam int CNT_W = $clog2(MAX_HITS + 1);
	localparam int HIT_W = $bits(hit_t);
	localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_HITS);
	localparam logic [8:0] GRID_LIM = 9'(GRID_DIM);

	typedef enum logic [24:0] {
		S_IDLE     = 25'd1 << 0,
		S_INIT     = 25'd1 << 1,
		S_PAIR_RD  = 25'd1 << 2,
		S_PAIR_EV  = 25'd1 << 3,
		S_SWEEP_RD = 25'd1 << 4,
		S_SWEEP_WR = 25'd1 << 5,
		S_ROOT_RD  = 25'd1 << 6,
		S_ROOT_EV  = 25'd1 << 7,
		S_NEXT     = 25'd1 << 8,
		S_ACC_RD   = 25'd1 << 9,
		S_ACC_EV   = 25'd1 << 10,
		S_ECHK     = 25'd1 << 11,
		S_LOGC     = 25'd1 << 12,
		S_WGT_RD   = 25'd1 << 13,
		S_WGT_EV   = 25'd1 << 14,
		S_LOGH     = 25'd1 << 15,
		S_MULW     = 25'd1 << 16,
		S_WSAT     = 25'd1 << 17,
		S_MULX     = 25'd1 << 18,
		S_MULY     = 25'd1 << 19,
		S_ACCY     = 25'd1 << 20,
		S_FIN      = 25'd1 << 21,
		S_DIVX     = 25'd1 << 22,
		S_DIVY     = 25'd1 << 23,
		S_OUT      = 25'd1 << 24
	} state_t;

	state_t state_q;
	logic [15:0] w0_q;
	logic [CNT_W-1:0] hit_total_q;
	logic overflow_q;
	logic [MAX_HITS-1:0] mapped_q;
	logic [MAX_HITS-1:0] root_q;
	logic pass_b_q;
	logic pair_end_q;
	logic [IDX_W-1:0] i_q, j_q, k_q;
	logic [IDX_W-1:0] merge_to_q, merge_from_q;
	logic [IDX_W-1:0] lroot_q, last_root_q;
	logic signed [31:0] energy_q;
	logic [15:0] tb_q, te_q;
	logic [CNT_W-1:0] cnt_q;
	logic [LOG_W-1:0] lc_q;
	logic signed [17:0] diff_q;
	logic signed [35:0] prod_q;
	logic [15:0] w_q;
	logic [SW_W-1:0] sw_q;
	logic signed [SUM_W-1:0] swx_q, swy_q;
	logic signed [15:0] xc_q;
	logic log_start_q;
	logic [31:0] log_arg_q;
	logic div_start_q;
	logic signed [SUM_W-1:0] div_num_q;

	logic out_valid_q;
	logic signed [31:0] out_energy_q;
	logic [15:0] out_tb_q, out_te_q;
	logic signed [15:0] out_x_q, out_y_q;
	logic [6:0] out_cnt_q;
	logic out_cv_q, out_drop_q, out_last_q;

	// RAM ports
	logic hit_we;
	logic [IDX_W-1:0] hit_waddr;
	hit_t hit_wdata;
	logic [HIT_W-1:0] hit_rd_a, hit_rd_b;
	hit_t ha, hb;
	logic lab_we;
	logic [IDX_W-1:0] lab_waddr, lab_wdata;
	logic [IDX_W-1:0] rd_addr_a;
	logic [IDX_W-1:0] lab_a, lab_b;

	log_res_t log_res;
	div_res_t div_res;

	logic in_accept;
	logic cfg_write;
	logic in_grid;
	logic [IDX_W-1:0] last_idx;
	logic [6:0] dr, dc;
	logic same_cell, adjacent;
	logic pair_last_j, pair_last, k_last;
	logic member, e_pos;
	logic signed [32:0] esum;
	logic signed [31:0] esat;
	logic signed [17:0] mul_a, mul_b;
	logic signed [35:0] mul_p;
	logic signed [35:0] rnd;
	logic signed [23:0] qw;
	logic signed [24:0] wfull;
	logic w_pos;
	logic [15:0] w_sat;
	logic out_load;

	assign in_stall = (state_q != S_IDLE);
	assign in_accept = in_valid && !in_stall;
	assign cfg_write = psel && penable && pwrite;
	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_LOG_WEIGHT_REF) ? {16'b0, w0_q} : 32'b0;

	always_comb begin
		hit_wdata.row = hit_row;
		hit_wdata.col = hit_col;
		hit_wdata.energy = hit_energy;
		hit_wdata.stamp = hit_time;
		hit_wdata.x = hit_x;
		hit_wdata.y = hit_y;
		hit_we = in_accept && (hit_total_q < MAX_CNT);
		hit_waddr = hit_total_q[IDX_W-1:0];
		in_grid = ({3'b0, hit_row} < GRID_LIM) && ({3'b0, hit_col} < GRID_LIM);
		rd_addr_a = ((state_q == S_PAIR_RD) || (state_q == S_PAIR_EV)) ? i_q : k_q;
		ha = hit_t'(hit_rd_a);
		hb = hit_t'(hit_rd_b);
	end

	always_comb begin
		last_idx = IDX_W'(hit_total_q - CNT_W'(1));
		same_cell = (ha.row == hb.row) && (ha.col == hb.col);
		dr = {1'b0, ha.row} - {1'b0, hb.row};
		dc = {1'b0, ha.col} - {1'b0, hb.col};
		adjacent = ((dr == 7'd0) || (dr == 7'd1) || (dr == 7'h7F)) &&
			((dc == 7'd0) || (dc == 7'd1) || (dc == 7'h7F)) &&
			mapped_q[i_q] && mapped_q[j_q];
		pair_last_j = (j_q == IDX_W'(i_q - IDX_W'(1)));
		pair_last = pair_last_j && (i_q == last_idx);
		k_last = (k_q == last_idx);
		member = (lab_a == lroot_q);
		e_pos = !ha.energy[24] && (ha.energy != 25'sd0);
		esum = {energy_q[31], energy_q} + {{8{ha.energy[24]}}, ha.energy};
		if (esum[32] != esum[31]) begin
			esat = esum[32] ? 32'sh80000000 : 32'sh7FFFFFFF;
		end else begin
			esat = esum[31:0];
		end
	end

	// One multiplier serves the ln2 scaling and both position products.
	always_comb begin
		case (state_q)
			S_MULW: begin
				mul_a = diff_q;
				mul_b = LN2_Q12;
			end
			S_MULX: begin
				mul_a = {2'b0, w_q};
				mul_b = {{2{ha.x[15]}}, ha.x};
			end
			default: begin
				mul_a = {2'b0, w_q};
				mul_b = {{2{ha.y[15]}}, ha.y};
			end
		endcase
		mul_p = mul_a * mul_b;
	end

	// Division by 4096 truncates toward zero, so negative products are biased first.
	always_comb begin
		rnd = prod_q + (prod_q[35] ? 36'sd4095 : 36'sd0);
		qw = rnd[35:12];
		wfull = $signed({9'b0, w0_q}) + {qw[23], qw};
		w_pos = !wfull[24] && (wfull != 25'sd0);
		w_sat = (|wfull[23:16]) ? 16'hFFFF : wfull[15:0];
	end

	always_comb begin
		lab_we = 1'b0;
		lab_waddr = k_q;
		lab_wdata = k_q;
		if (state_q == S_INIT) begin
			lab_we = 1'b1;
		end else if ((state_q == S_SWEEP_WR) && (lab_a == merge_from_q)) begin
			lab_we = 1'b1;
			lab_wdata = merge_to_q;
		end
	end

	chc_ram #(.WIDTH(HIT_W), .DEPTH(MAX_HITS)) u_hit_ram (
		.clk     (clk),
		.we      (hit_we),
		.waddr   (hit_waddr),
		.wdata   (hit_wdata),
		.raddr_a (rd_addr_a),
		.raddr_b (j_q),
		.rdata_a (hit_rd_a),
		.rdata_b (hit_rd_b)
	);

	chc_ram #(.WIDTH(IDX_W), .DEPTH(MAX_HITS)) u_label_ram (
		.clk     (clk),
		.we      (lab_we),
		.waddr   (lab_waddr),
		.wdata   (lab_wdata),
		.raddr_a (rd_addr_a),
		.raddr_b (j_q),
		.rdata_a (lab_a),
		.rdata_b (lab_b)
	);

	chc_log2 #(.LOG_TABLE_BITS(LOG_TABLE_BITS)) u_log2 (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (log_start_q),
		.value  (log_arg_q),
		.res    (log_res)
	);

	chc_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start_q),
		.dividend (div_num_q),
		.divisor  (sw_q),
		.res      (div_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w0_q <= 16'd17203;
		end else if (cfg_write && (paddr[2] == REG_LOG_WEIGHT_REF)) begin
			w0_q <= pwdata[15:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			hit_total_q <= '0;
			overflow_q <= 1'b0;
			mapped_q <= '0;
			root_q <= '0;
			pass_b_q <= 1'b0;
			pair_end_q <= 1'b0;
			i_q <= '0;
			j_q <= '0;
			k_q <= '0;
			merge_to_q <= '0;
			merge_from_q <= '0;
			lroot_q <= '0;
			last_root_q <= '0;
			energy_q <= '0;
			tb_q <= '0;
			te_q <= '0;
			cnt_q <= '0;
			lc_q <= '0;
			diff_q <= '0;
			prod_q <= '0;
			w_q <= '0;
			sw_q <= '0;
			swx_q <= '0;
			swy_q <= '0;
			xc_q <= '0;
			log_start_q <= 1'b0;
			log_arg_q <= '0;
			div_start_q <= 1'b0;
			div_num_q <= '0;
		end else begin
			log_start_q <= 1'b0;
			div_start_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (in_accept) begin
						if (hit_total_q < MAX_CNT) begin
							mapped_q[hit_total_q[IDX_W-1:0]] <= in_grid;
							hit_total_q <= hit_total_q + CNT_W'(1);
						end else begin
							overflow_q <= 1'b1;
						end
						if (last_hit) begin
							k_q <= '0;
							state_q <= S_INIT;
						end
					end
				end
				S_INIT: begin
					if (k_last) begin
						k_q <= '0;
						if (hit_total_q == CNT_W'(1)) begin
							state_q <= S_ROOT_RD;
						end else begin
							i_q <= IDX_W'(1);
							j_q <= '0;
							pass_b_q <= 1'b0;
							state_q <= S_PAIR_RD;
						end
					end else begin
						k_q <= k_q + IDX_W'(1);
					end
				end
				S_PAIR_RD: begin
					state_q <= S_PAIR_EV;
				end
				S_PAIR_EV: begin
					// The first pass unmaps hits replaced by a later hit on the same cell, so they merge with no neighbour.
					if (!pass_b_q && same_cell) begin
						mapped_q[j_q] <= 1'b0;
					end
					if (!pair_last) begin
						if (pair_last_j) begin
							i_q <= i_q + IDX_W'(1);
							j_q <= '0;
						end else begin
							j_q <= j_q + IDX_W'(1);
						end
					end
					if (pass_b_q && adjacent && (lab_a != lab_b)) begin
						merge_to_q <= (lab_a < lab_b) ? lab_a : lab_b;
						merge_from_q <= (lab_a < lab_b) ? lab_b : lab_a;
						pair_end_q <= pair_last;
						k_q <= '0;
						state_q <= S_SWEEP_RD;
					end else if (pair_last) begin
						if (!pass_b_q) begin
							pass_b_q <= 1'b1;
							i_q <= IDX_W'(1);
							j_q <= '0;
							state_q <= S_PAIR_RD;
						end else begin
							k_q <= '0;
							state_q <= S_ROOT_RD;
						end
					end else begin
						state_q <= S_PAIR_RD;
					end
				end
				S_SWEEP_RD: begin
					state_q <= S_SWEEP_WR;
				end
				S_SWEEP_WR: begin
					if (k_last) begin
						k_q <= '0;
						state_q <= pair_end_q ? S_ROOT_RD : S_PAIR_RD;
					end else begin
						k_q <= k_q + IDX_W'(1);
						state_q <= S_SWEEP_RD;
					end
				end
				S_ROOT_RD: begin
					state_q <= S_ROOT_EV;
				end
				S_ROOT_EV: begin
					// Labels hold the lowest hit index of each component.
					root_q[k_q] <= (lab_a == k_q);
					if (lab_a == k_q) begin
						last_root_q <= k_q;
					end
					if (k_last) begin
						lroot_q <= '0;
						state_q <= S_NEXT;
					end else begin
						k_q <= k_q + IDX_W'(1);
						state_q <= S_ROOT_RD;
					end
				end
				S_NEXT: begin
					if (root_q[lroot_q]) begin
						energy_q <= '0;
						tb_q <= 16'hFFFF;
						te_q <= '0;
						cnt_q <= '0;
						sw_q <= '0;
						swx_q <= '0;
						swy_q <= '0;
						k_q <= '0;
						state_q <= S_ACC_RD;
					end else begin
						lroot_q <= lroot_q + IDX_W'(1);
					end
				end
				S_ACC_RD: begin
					state_q <= S_ACC_EV;
				end
				S_ACC_EV: begin
					if (member) begin
						energy_q <= esat;
						if (ha.stamp < tb_q) begin
							tb_q <= ha.stamp;
						end
						if (ha.stamp > te_q) begin
							te_q <= ha.stamp;
						end
						cnt_q <= cnt_q + CNT_W'(1);
					end
					if (k_last) begin
						state_q <= S_ECHK;
					end else begin
						k_q <= k_q + IDX_W'(1);
						state_q <= S_ACC_RD;
					end
				end
				S_ECHK: begin
					if (!energy_q[31] && (energy_q != 32'sd0)) begin
						log_arg_q <= {1'b0, energy_q[30:0]};
						log_start_q <= 1'b1;
						state_q <= S_LOGC;
					end else begin
						state_q <= S_FIN;
					end
				end
				S_LOGC: begin
					if (log_res.done) begin
						lc_q <= log_res.value;
						k_q <= '0;
						state_q <= S_WGT_RD;
					end
				end
				S_WGT_RD: begin
					state_q <= S_WGT_EV;
				end
				S_WGT_EV: begin
					if (member && e_pos) begin
						log_arg_q <= {8'b0, ha.energy[23:0]};
						log_start_q <= 1'b1;
						state_q <= S_LOGH;
					end else if (k_last) begin
						state_q <= S_FIN;
					end else begin
						k_q <= k_q + IDX_W'(1);
						state_q <= S_WGT_RD;
					end
				end
				S_LOGH: begin
					if (log_res.done) begin
						diff_q <= $signed({1'b0, log_res.value}) - $signed({1'b0, lc_q});
						state_q <= S_MULW;
					end
				end
				S_MULW: begin
					prod_q <= mul_p;
					state_q <= S_WSAT;
				end
				S_WSAT: begin
					if (w_pos) begin
						w_q <= w_sat;
						state_q <= S_MULX;
					end else if (k_last) begin
						state_q <= S_FIN;
					end else begin
						k_q <= k_q + IDX_W'(1);
						state_q <= S_WGT_RD;
					end
				end
				S_MULX: begin
					prod_q <= mul_p;
					state_q <= S_MULY;
				end
				S_MULY: begin
					swx_q <= swx_q + {{4{prod_q[35]}}, prod_q};
					sw_q <= sw_q + SW_W'(w_q);
					prod_q <= mul_p;
					state_q <= S_ACCY;
				end
				S_ACCY: begin
					swy_q <= swy_q + {{4{prod_q[35]}}, prod_q};
					if (k_last) begin
						state_q <= S_FIN;
					end else begin
						k_q <= k_q + IDX_W'(1);
						state_q <= S_WGT_RD;
					end
				end
				S_FIN: begin
					if (sw_q == '0) begin
						state_q <= S_OUT;
					end else begin
						div_num_q <= swx_q;
						div_start_q <= 1'b1;
						state_q <= S_DIVX;
					end
				end
				S_DIVX: begin
					if (div_res.done) begin
						xc_q <= div_res.quotient;
						div_num_q <= swy_q;
						div_start_q <= 1'b1;
						state_q <= S_DIVY;
					end
				end
				S_DIVY: begin
					if (div_res.done) begin
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (!out_stall) begin
						if (lroot_q == last_root_q) begin
							hit_total_q <= '0;
							overflow_q <= 1'b0;
							state_q <= S_IDLE;
						end else begin
							lroot_q <= lroot_q + IDX_W'(1);
							state_q <= S_NEXT;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_load = ((state_q == S_FIN) && (sw_q == '0)) ||
		((state_q == S_DIVY) && div_res.done);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			out_energy_q <= '0;
			out_tb_q <= '0;
			out_te_q <= '0;
			out_x_q <= '0;
			out_y_q <= '0;
			out_cnt_q <= '0;
			out_cv_q <= 1'b0;
			out_drop_q <= 1'b0;
			out_last_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
			out_energy_q <= energy_q;
			out_tb_q <= tb_q;
			out_te_q <= te_q;
			out_x_q <= (sw_q == '0) ? 16'sd0 : xc_q;
			out_y_q <= (sw_q == '0) ? 16'sd0 : div_res.quotient;
			out_cnt_q <= 7'(cnt_q);
			out_cv_q <= (sw_q != '0);
			out_drop_q <= overflow_q;
			out_last_q <= (lroot_q == last_root_q);
		end else if (out_valid_q && !out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign cluster_energy = out_energy_q;
	assign time_begin = out_tb_q;
	assign time_end = out_te_q;
	assign x_center = out_x_q;
	assign y_center = out_y_q;
	assign hit_count = out_cnt_q;
	assign centroid_valid = out_cv_q;
	assign hits_dropped = out_drop_q;
	assign last_cluster = out_last_q;
endmodule

FILE: tb/calorimeter_hit_clusterer_tb.sv
// Testbench of the calorimeter hit clusterer: random hit events checked against a cluster predictor.
`timescale 1ns / 1ps
module calorimeter_hit_clusterer_tb;
	import chc_pkg::*;

	localparam int NHITS = 64;
	localparam int GRID = 64;
	localparam int CYCLE_LIMIT = 2000000;

	typedef struct packed {
		logic signed [31:0] energy;
		logic [15:0] t_begin;
		logic [15:0] t_end;
		logic signed [15:0] xc;
		logic signed [15:0] yc;
		logic [6:0] count;
		logic cvalid;
		logic dropped;
		logic last;
	} cluster_t;

	class cluster_scoreboard;
		hit_t event_hits[$];
		bit overflow;
		logic [15:0] w0;
		cluster_t pending[$];
		int mismatches;
		int errors;
		int frac_tbl[64];
		int cell_owner[GRID * GRID];
		int parent[NHITS];

		function new();
			longint unsigned m;
			int f;
			for (int k = 0; k < 64; k++) begin
				m = (64'd1 << 30) + (64'(k) << 24);
				f = 0;
				for (int b = 0; b < 16; b++) begin
					m = (m * m) >> 30;
					f = f << 1;
					if (m >= (64'd2 << 30)) begin
						m = m >> 1;
						f = f | 1;
					end
				end
				frac_tbl[k] = (f + 8) >> 4;
			end
			w0 = 16'd17203;
		endfunction

		function longint log2_q12(longint unsigned v);
			int p;
			longint unsigned idx;
			p = 0;
			while (p < 63 && (v >> (p + 1)) != 0)
				p++;
			idx = (p >= 6) ? (v >> (p - 6)) : (v << (6 - p));
			return longint'(p) * 4096 + frac_tbl[idx & 63];
		endfunction

		function int root_of(int a);
			while (parent[a] != a)
				a = parent[a];
			return a;
		endfunction

		function void merge(int a, int r, int c);
			int ra;
			int rb;
			if (r < 0 || c < 0 || r >= GRID || c >= GRID || cell_owner[r * GRID + c] < 0)
				return;
			ra = root_of(a);
			rb = root_of(cell_owner[r * GRID + c]);
			if (ra != rb)
				parent[rb] = ra;
		endfunction

		// Forms clusters over the loaded event and queues one record per cluster.
		function void cluster_event();
			int n;
			int nslots;
			int v;
			int slot_of[NHITS];
			longint esum[NHITS];
			longint sw[NHITS];
			longint swx[NHITS];
			longint swy[NHITS];
			longint l;
			longint w;
			cluster_t rec[NHITS];
			n = event_hits.size();
			nslots = 0;
			foreach (cell_owner[k]) cell_owner[k] = -1;
			for (int i = 0; i < n; i++) begin
				parent[i] = i;
				slot_of[i] = -1;
				cell_owner[event_hits[i].row * GRID + event_hits[i].col] = i;
			end
			for (int r = 0; r < GRID; r++)
				for (int c = 0; c < GRID; c++) begin
					v = cell_owner[r * GRID + c];
					if (v >= 0) begin
						merge(v, r - 1, c);
						merge(v, r, c - 1);
						merge(v, r - 1, c - 1);
						merge(v, r - 1, c + 1);
					end
				end
			for (int i = 0; i < n; i++) begin
				v = root_of(i);
				if (slot_of[v] < 0) begin
					slot_of[v] = nslots;
					esum[nslots] = 0;
					sw[nslots] = 0;
					swx[nslots] = 0;
					swy[nslots] = 0;
					rec[nslots] = '0;
					rec[nslots].t_begin = 16'hFFFF;
					nslots++;
				end
				v = slot_of[v];
				esum[v] += event_hits[i].energy;
				if (esum[v] > 64'sd2147483647) esum[v] = 64'sd2147483647;
				if (esum[v] < -64'sd2147483648) esum[v] = -64'sd2147483648;
				if (event_hits[i].stamp < rec[v].t_begin) rec[v].t_begin = event_hits[i].stamp;
				if (event_hits[i].stamp > rec[v].t_end) rec[v].t_end = event_hits[i].stamp;
				rec[v].count++;
			end
			for (int i = 0; i < n; i++) begin
				v = slot_of[root_of(i)];
				if (event_hits[i].energy > 0 && esum[v] > 0) begin
					l = log2_q12(longint'(event_hits[i].energy)) - log2_q12(esum[v]);
					w = longint'(w0) + (l * 2839) / 4096;
					if (w > 0) begin
						if (w > 65535) w = 65535;
						sw[v] += w;
						swx[v] += w * longint'(event_hits[i].x);
						swy[v] += w * longint'(event_hits[i].y);
					end
				end
			end
			for (int s = 0; s < nslots; s++) begin
				rec[s].energy = 32'(esum[s]);
				if (sw[s] > 0) begin
					rec[s].xc = 16'(swx[s] / sw[s]);
					rec[s].yc = 16'(swy[s] / sw[s]);
					rec[s].cvalid = 1'b1;
				end
				rec[s].dropped = overflow;
				rec[s].last = (s == nslots - 1);
				pending = {pending, rec[s]};
			end
			event_hits.delete();
			overflow = 0;
		endfunction

		function void note_hit(hit_t h, bit last);
			if (event_hits.size() < NHITS)
				event_hits = {event_hits, h};
			else
				overflow = 1;
			if (last)
				cluster_event();
		endfunction

		function void check_cluster(cluster_t got);
			cluster_t exp_c;
			if (pending.size() == 0) begin
				errors++;
				if (mismatches++ < 10)
					$display("ERROR: unexpected cluster transfer %p", got);
				return;
			end
			exp_c = pending.pop_front();
			if (got.energy !== exp_c.energy || got.t_begin !== exp_c.t_begin ||
					got.t_end !== exp_c.t_end || got.xc !== exp_c.xc || got.yc !== exp_c.yc ||
					got.count !== exp_c.count || got.cvalid !== exp_c.cvalid ||
					got.dropped !== exp_c.dropped || got.last !== exp_c.last) begin
				errors++;
				if (mismatches++ < 10) begin
					$display("ERROR: cluster mismatch");
					$display("  expected %p", exp_c);
					$display("  actual   %p", got);
				end
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic psel, penable, pwrite;
	logic [2:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic pready;
	logic in_valid, in_stall;
	logic [5:0] hit_row, hit_col;
	logic signed [24:0] hit_energy;
	logic [15:0] hit_time;
	logic signed [15:0] hit_x, hit_y;
	logic last_hit;
	logic out_valid, out_stall;
	logic signed [31:0] cluster_energy;
	logic [15:0] time_begin, time_end;
	logic signed [15:0] x_center, y_center;
	logic [6:0] hit_count;
	logic centroid_valid, hits_dropped, last_cluster;

	cluster_scoreboard sb = new();
	int cycles;
	int clusters_seen;
	bit no_gaps;

	calorimeter_hit_clusterer uut (.*);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
		if (arst_n && in_valid && !in_stall)
			sb.note_hit('{hit_row, hit_col, hit_energy, hit_time, hit_x, hit_y}, last_hit);
		if (arst_n && out_valid && !out_stall) begin
			sb.check_cluster('{cluster_energy, time_begin, time_end, x_center, y_center,
				hit_count, centroid_valid, hits_dropped, last_cluster});
			clusters_seen <= clusters_seen + 1;
		end
	end

	// Result side: random stalls, and one long hold so the block backs up its input.
	initial begin
		int gap;
		bit held;
		out_stall = 1'b1;
		held = 0;
		@(posedge arst_n);
		forever begin
			gap = no_gaps ? 0 : $urandom_range(0, 19);
			if (!held && clusters_seen >= 30) begin
				held = 1;
				gap = 3000;
			end
			if (gap > 0) begin
				@(negedge clk);
				out_stall <= 1'b1;
				repeat (gap - 1) @(negedge clk);
			end
			@(negedge clk);
			out_stall <= 1'b0;
			do @(posedge clk); while (!out_valid);
		end
	end

	task automatic write_weight(logic [15:0] value);
		@(negedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		paddr <= 3'(REG_LOG_WEIGHT_REF) * 3'd4;
		pwdata <= {16'h0, value};
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		sb.w0 = value;
	endtask

	task automatic send_hit(hit_t h, bit last);
		int gap;
		gap = no_gaps ? 0 : $urandom_range(0, 19);
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		hit_row <= h.row;
		hit_col <= h.col;
		hit_energy <= h.energy;
		hit_time <= h.stamp;
		hit_x <= h.x;
		hit_y <= h.y;
		last_hit <= last;
		do @(posedge clk); while (in_stall);
		// The event is complete, so the input goes quiet until the next one.
		if (last) begin
			@(negedge clk);
			in_valid <= 1'b0;
		end
	endtask

	function automatic hit_t random_hit(int base_r, int base_c, bit spread);
		hit_t h;
		h.row = spread ? 6'($urandom) : 6'(base_r + $urandom_range(0, 5));
		h.col = spread ? 6'($urandom) : 6'(base_c + $urandom_range(0, 5));
		case ($urandom_range(0, 9))
			0: h.energy = 25'($urandom);
			1: h.energy = -25'($urandom_range(0, 5000));
			2: h.energy = 25'($urandom_range(1, 16777215));
			default: h.energy = 25'($urandom_range(1, 200000));
		endcase
		h.stamp = 16'($urandom);
		h.x = 16'($urandom);
		h.y = 16'($urandom);
		return h;
	endfunction

	task automatic random_event(int n);
		int br;
		int bc;
		bit spread;
		br = $urandom_range(0, 58);
		bc = $urandom_range(0, 58);
		spread = ($urandom_range(0, 4) == 0);
		no_gaps = ($urandom_range(0, 3) == 0);
		for (int i = 0; i < n; i++)
			send_hit(random_hit(br, bc, spread), i == n - 1);
	endtask

	task automatic wait_drained();
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	initial begin
		logic [15:0] weights[5];
		int items;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		in_valid = 1'b0;
		hit_row = '0;
		hit_col = '0;
		hit_energy = '0;
		hit_time = '0;
		hit_x = '0;
		hit_y = '0;
		last_hit = 1'b0;
		cycles = 0;
		clusters_seen = 0;
		no_gaps = 0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: a lone maximum hit, then neighbors in all directions, both diagonals,
		// grid corners, a repeated cell and a cluster with no positive energy.
		send_hit('{6'd0, 6'd0, 25'sd16777215, 16'd0, 16'sh7FFF, -16'sh8000}, 1);
		send_hit('{6'd0, 6'd0, 25'sd1000, 16'd65535, -16'sh8000, 16'sh7FFF}, 0);
		send_hit('{6'd1, 6'd1, 25'sd3000, 16'd100, 16'sd500, 16'sd600}, 0);
		send_hit('{6'd0, 6'd63, 25'sd2000, 16'd7, 16'sd10, -16'sd10}, 0);
		send_hit('{6'd1, 6'd62, 25'sd40, 16'd9, -16'sd20, 16'sd30}, 0);
		send_hit('{6'd63, 6'd63, -25'sd16777216, 16'd5, 16'sd1, 16'sd1}, 0);
		send_hit('{6'd62, 6'd63, 25'sd0, 16'd6, 16'sd2, 16'sd2}, 0);
		send_hit('{6'd20, 6'd20, 25'sd500, 16'd50, 16'sd100, 16'sd100}, 0);
		send_hit('{6'd20, 6'd20, 25'sd700, 16'd60, 16'sd200, -16'sd200}, 0);
		send_hit('{6'd21, 6'd20, 25'sd900, 16'd70, -16'sd300, 16'sd300}, 0);
		send_hit('{6'd40, 6'd40, 25'sd1, 16'd1, 16'sd5, 16'sd5}, 0);
		send_hit('{6'd40, 6'd41, 25'sd16777215, 16'd2, 16'sd9, 16'sd9}, 0);
		send_hit('{6'd63, 6'd0, -25'sd1, 16'd3, 16'sd0, 16'sd0}, 0);
		send_hit('{6'd10, 6'd30, 25'sd12345, 16'd4, 16'sd77, -16'sd77}, 1);
		wait_drained();

		weights[0] = 16'd17203;
		weights[1] = 16'd0;
		weights[2] = 16'd65535;
		weights[3] = 16'($urandom_range(1, 65534));
		weights[4] = 16'd4096;
		for (int p = 0; p < 5; p++) begin
			write_weight(weights[p]);
			items = 0;
			if (p == 2) begin
				random_event(66);
				items += 66;
			end
			while (items < 24) begin
				int n;
				n = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 30) : $urandom_range(1, 12);
				random_event(n);
				items += n;
			end
			wait_drained();
		end

		repeat (50) @(posedge clk);
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end
endmodule
